// File: sv/probability_step_sequencer_defines.svh
// Assertion macros shared by the sequencer RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef PROBABILITY_STEP_SEQUENCER_DEFINES_SVH
`define PROBABILITY_STEP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSS_ASSERT_IMPL(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSS_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: sv/pss_pkg.sv
// Package of the probability step sequencer: commands, register indexes,
// sequencer states and numeric constants. No dependencies.
package pss_pkg;

    localparam int SEQ_COUNT_DEF  = 4;
    localparam int STEP_COUNT_DEF = 32;

    localparam int Q12_ONE     = 4096;
    localparam int PITCH_LIMIT = 1024;
    localparam int CLOCK_LANES = 4;

    localparam logic [31:0] LFSR_MASK = 32'hA300_0000;
    localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

    localparam longint unsigned PI_Q28  = 64'd843314857;
    localparam longint unsigned ONE_Q28 = 64'd268435456;

    localparam logic [3:0] PATTERN_RANDOM = 4'd8;

    typedef enum logic [2:0] {
        CMD_CLOCK_ALL    = 3'd0,
        CMD_CLOCK_ONE    = 3'd1,
        CMD_ARM_RESET    = 3'd2,
        CMD_LOAD_PATTERN = 3'd3,
        CMD_INVERT       = 3'd4,
        CMD_DIMINISH     = 3'd5,
        CMD_WRITE_ENTRY  = 3'd6,
        CMD_UNUSED       = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        REG_LENGTH_A = 3'd0,
        REG_LENGTH_B = 3'd1,
        REG_LENGTH_C = 3'd2,
        REG_LENGTH_D = 3'd3,
        REG_SPREAD_A = 3'd4,
        REG_SPREAD_B = 3'd5,
        REG_SPREAD_C = 3'd6,
        REG_SPREAD_D = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP_START,
        ST_STEP_MOD,
        ST_STEP_MUL,
        ST_STEP_OUT,
        ST_PAT,
        ST_RMW_READ,
        ST_RMW_WRITE
    } state_t;

endpackage

// File: sv/probability_step_sequencer.sv
// Top level of the probability step sequencer: probability store, command
// sequencer and configuration registers. Depends on pss_pkg and the defines header.
//
// Usage: commands arrive on the in_* channel (valid/ready), one item each.
// Clock commands (all, or one sequence) produce one result item per stepped
// sequence on the out_* channel, with last set on the final one; all other
// commands produce nothing. Configuration writes use cfg_valid/cfg_ready with
// cfg_index and cfg_data and are always taken.
// Timing: a clock command takes each sequence through the states STEP_START,
// STEP_MOD (iterative subtraction of the position modulo the length, ending
// with the store read), STEP_MUL and STEP_OUT, which waits for a free output
// register. Load pattern writes one store entry per cycle; invert and diminish
// read each entry, then write it back; write entry is done in the idle state.
// Reset: the store is cleared by a pass over all SEQ_COUNT * STEP_COUNT
// entries (128 by default), during which no item is accepted.
// Stall: a result waits in the output register; the sequencer holds its next
// result until that register is free, and then in_ready follows.
`include "probability_step_sequencer_defines.svh"

module probability_step_sequencer #(
    parameter int SEQ_COUNT  = pss_pkg::SEQ_COUNT_DEF,
    parameter int STEP_COUNT = pss_pkg::STEP_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic [1:0]         sequence_req,
    input  logic [3:0]         pattern,
    input  logic [4:0]         entry_index,
    input  logic [12:0]        entry_value,
    input  logic [11:0]        draw_0,
    input  logic [11:0]        draw_1,
    input  logic [11:0]        draw_2,
    input  logic [11:0]        draw_3,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         seq_id,
    output logic [4:0]         step_pos,
    output logic               gate,
    output logic signed [11:0] pitch,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [11:0]        cfg_data
);

    localparam int DEPTH      = SEQ_COUNT * STEP_COUNT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int STEP_W     = $clog2(STEP_COUNT);
    localparam int SEQ_W      = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
    localparam int HALF       = (STEP_COUNT + 1) / 2;
    localparam int CLOCK_SEQS = (SEQ_COUNT < pss_pkg::CLOCK_LANES) ? SEQ_COUNT
                                                                   : pss_pkg::CLOCK_LANES;

    logic [12:0] sine_tab [STEP_COUNT];
    logic [12:0] ramp_tab [STEP_COUNT];

    for (genvar g = 0; g < STEP_COUNT; g++) begin : g_tab
        localparam longint unsigned D  = STEP_COUNT - 1;
        localparam longint unsigned A  = (2 * g > STEP_COUNT - 1) ? (STEP_COUNT - 1 - g) : g;
        localparam longint unsigned X  = (pss_pkg::PI_Q28 * A) / D;
        localparam longint unsigned X2 = (X * X) >> 28;
        localparam longint unsigned T0 = pss_pkg::ONE_Q28 - ((X2 * pss_pkg::ONE_Q28) >> 28) / 110;
        localparam longint unsigned T1 = pss_pkg::ONE_Q28 - ((X2 * T0) >> 28) / 72;
        localparam longint unsigned T2 = pss_pkg::ONE_Q28 - ((X2 * T1) >> 28) / 42;
        localparam longint unsigned T3 = pss_pkg::ONE_Q28 - ((X2 * T2) >> 28) / 20;
        localparam longint unsigned T4 = pss_pkg::ONE_Q28 - ((X2 * T3) >> 28) / 6;
        localparam longint unsigned S  = (X * T4) >> 28;
        localparam longint unsigned R  = (S + 32768) >> 16;
        localparam longint unsigned SV = (R > pss_pkg::Q12_ONE) ? pss_pkg::Q12_ONE : R;
        localparam longint unsigned RV = ((g + 1) * pss_pkg::Q12_ONE + STEP_COUNT / 2)
                                         / STEP_COUNT;
        assign sine_tab[g] = 13'(SV);
        assign ramp_tab[g] = 13'(RV);
    end

    // Probability store.
    logic [12:0]       mem [DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [12:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [12:0]       rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SEQ_W-1:0] s,
                                                  input logic [STEP_W-1:0] i);
        return ADDR_W'(int'(s) * STEP_COUNT + int'(i));
    endfunction

    pss_pkg::state_t          state_reg, state_next;
    logic [ADDR_W-1:0]        clr_reg, clr_next;
    logic [STEP_W-1:0]        idx_reg, idx_next;
    logic [SEQ_W-1:0]         seq_reg, seq_next;
    logic [SEQ_W-1:0]         last_seq_reg, last_seq_next;
    logic                     one_reg, one_next;
    pss_pkg::cmd_t            cmd_reg, cmd_next;
    logic [3:0]               pat_reg, pat_next;
    logic [11:0]              draw_reg [4];
    logic [11:0]              draw_next [4];
    logic [6:0]               len_reg, len_next;
    logic [6:0]               rem_reg, rem_next;
    logic signed [25:0]       prod_reg, prod_next;
    logic                     gate_reg, gate_next;
    logic [5:0]               pos_reg [SEQ_COUNT];
    logic [5:0]               pos_next [SEQ_COUNT];
    logic                     started_reg [SEQ_COUNT];
    logic                     started_next [SEQ_COUNT];
    logic [6:0]               slen_reg [SEQ_COUNT];
    logic [6:0]               slen_next [SEQ_COUNT];
    logic                     armed_reg, armed_next;
    logic [31:0]              lfsr_reg, lfsr_next;
    logic [5:0]               length_reg [4];
    logic [5:0]               length_next [4];
    logic [11:0]              spread_reg [4];
    logic [11:0]              spread_next [4];
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               seq_id_reg, seq_id_next;
    logic [4:0]               step_pos_reg, step_pos_next;
    logic                     gate_out_reg, gate_out_next;
    logic [11:0]              pitch_reg, pitch_next;
    logic                     last_reg, last_next;

    logic              out_free;
    logic              seq_ok;
    logic [1:0]        cfg_sel;
    logic [5:0]        len_raw;
    logic [11:0]       draw_cur;
    logic signed [13:0] centered;
    logic [25:0]       mag;
    logic [25:0]       qmag;
    logic [10:0]       qsat;
    logic [31:0]       lfsr_step;
    logic [12:0]       pat_val;
    logic [STEP_W:0]   dim_src;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == pss_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign seq_ok    = int'(sequence_req) < SEQ_COUNT;
    assign cfg_sel   = 2'(seq_reg);
    assign len_raw   = length_reg[cfg_sel];
    assign draw_cur  = one_reg ? draw_reg[0] : draw_reg[cfg_sel];
    assign centered  = 14'($signed({2'b00, rd_data_reg, 1'b0}) - 16'sd4096);
    assign mag       = prod_reg[25] ? 26'(-prod_reg) : 26'(prod_reg);
    assign qmag      = (mag + 26'd2048) >> 12;
    assign qsat      = (qmag > 26'(pss_pkg::PITCH_LIMIT)) ? 11'(pss_pkg::PITCH_LIMIT)
                                                           : qmag[10:0];
    assign lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? pss_pkg::LFSR_MASK : 32'd0);
    assign dim_src   = (int'(idx_reg) < HALF) ? (STEP_W + 1)'({idx_reg, 1'b0})
                                             : (STEP_W + 1)'(int'(idx_reg) - HALF);

    always_comb
    begin
        unique case (pat_reg)
            4'd0:    pat_val = 13'd0;
            4'd1:    pat_val = 13'(pss_pkg::Q12_ONE / 2);
            4'd2:    pat_val = 13'(pss_pkg::Q12_ONE);
            4'd3:    pat_val = ((32'(idx_reg) & 32'd7) == 32'd0) ? 13'(pss_pkg::Q12_ONE) : 13'd0;
            4'd4:    pat_val = ((32'(idx_reg) & 32'd7) == 32'd4) ? 13'(pss_pkg::Q12_ONE) : 13'd0;
            4'd5:    pat_val = ((32'(idx_reg) & 32'd3) == 32'd0) ? 13'(pss_pkg::Q12_ONE) : 13'd0;
            4'd6:    pat_val = ramp_tab[idx_reg];
            4'd7:    pat_val = sine_tab[idx_reg];
            default: pat_val = {1'b0, lfsr_step[31:20]};
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        seq_next       = seq_reg;
        last_seq_next  = last_seq_reg;
        one_next       = one_reg;
        cmd_next       = cmd_reg;
        pat_next       = pat_reg;
        draw_next      = draw_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        prod_next      = prod_reg;
        gate_next      = gate_reg;
        pos_next       = pos_reg;
        started_next   = started_reg;
        slen_next      = slen_reg;
        armed_next     = armed_reg;
        lfsr_next      = lfsr_reg;
        length_next    = length_reg;
        spread_next    = spread_reg;
        out_valid_next = out_valid_reg && !out_ready;
        seq_id_next    = seq_id_reg;
        step_pos_next  = step_pos_reg;
        gate_out_next  = gate_out_reg;
        pitch_next     = pitch_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_of(seq_reg, idx_reg);
        mem_wdata      = 13'd0;
        mem_re         = 1'b0;
        mem_raddr      = addr_of(seq_reg, idx_reg);

        if (cfg_valid)
        begin
            unique case (pss_pkg::reg_index_t'(cfg_index))
                pss_pkg::REG_LENGTH_A: length_next[0] = cfg_data[5:0];
                pss_pkg::REG_LENGTH_B: length_next[1] = cfg_data[5:0];
                pss_pkg::REG_LENGTH_C: length_next[2] = cfg_data[5:0];
                pss_pkg::REG_LENGTH_D: length_next[3] = cfg_data[5:0];
                pss_pkg::REG_SPREAD_A: spread_next[0] = cfg_data;
                pss_pkg::REG_SPREAD_B: spread_next[1] = cfg_data;
                pss_pkg::REG_SPREAD_C: spread_next[2] = cfg_data;
                pss_pkg::REG_SPREAD_D: spread_next[3] = cfg_data;
            endcase
        end

        unique case (state_reg)
            pss_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (int'(clr_reg) == DEPTH - 1)
                begin
                    state_next = pss_pkg::ST_IDLE;
                end
            end
            pss_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = pss_pkg::cmd_t'(command);
                    pat_next     = pattern;
                    draw_next[0] = draw_0;
                    draw_next[1] = draw_1;
                    draw_next[2] = draw_2;
                    draw_next[3] = draw_3;
                    idx_next     = '0;
                    seq_next     = SEQ_W'(sequence_req);
                    if (command == pss_pkg::CMD_ARM_RESET)
                    begin
                        armed_next = 1'b1;
                    end
                    else if (command == pss_pkg::CMD_CLOCK_ALL ||
                             (command == pss_pkg::CMD_CLOCK_ONE && seq_ok))
                    begin
                        if (armed_reg)
                        begin
                            armed_next = 1'b0;
                            for (int s = 0; s < SEQ_COUNT; s++)
                            begin
                                pos_next[s]     = 6'(slen_reg[s] - 7'd1);
                                started_next[s] = 1'b1;
                            end
                        end
                        one_next   = (command == pss_pkg::CMD_CLOCK_ONE);
                        state_next = pss_pkg::ST_STEP_START;
                        if (command == pss_pkg::CMD_CLOCK_ALL)
                        begin
                            seq_next      = '0;
                            last_seq_next = SEQ_W'(CLOCK_SEQS - 1);
                        end
                        else
                        begin
                            last_seq_next = SEQ_W'(sequence_req);
                        end
                    end
                    else if (seq_ok)
                    begin
                        unique case (command)
                            pss_pkg::CMD_LOAD_PATTERN: state_next = pss_pkg::ST_PAT;
                            pss_pkg::CMD_INVERT:       state_next = pss_pkg::ST_RMW_READ;
                            pss_pkg::CMD_DIMINISH:     state_next = pss_pkg::ST_RMW_READ;
                            pss_pkg::CMD_WRITE_ENTRY:
                            begin
                                if (int'(entry_index) < STEP_COUNT)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = addr_of(SEQ_W'(sequence_req),
                                                        STEP_W'(entry_index));
                                    mem_wdata = (entry_value > 13'(pss_pkg::Q12_ONE))
                                                ? 13'(pss_pkg::Q12_ONE) : entry_value;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            pss_pkg::ST_STEP_START:
            begin
                if (len_raw == 6'd0)
                begin
                    len_next = 7'd1;
                end
                else if (int'(len_raw) > STEP_COUNT)
                begin
                    len_next = 7'(STEP_COUNT);
                end
                else
                begin
                    len_next = {1'b0, len_raw};
                end
                rem_next   = started_reg[seq_reg] ? ({1'b0, pos_reg[seq_reg]} + 7'd1) : 7'd0;
                state_next = pss_pkg::ST_STEP_MOD;
            end
            pss_pkg::ST_STEP_MOD:
            begin
                if (rem_reg >= len_reg)
                begin
                    rem_next = rem_reg - len_reg;
                end
                else
                begin
                    pos_next[seq_reg]     = rem_reg[5:0];
                    started_next[seq_reg] = 1'b1;
                    slen_next[seq_reg]    = len_reg;
                    mem_re                = 1'b1;
                    mem_raddr             = addr_of(seq_reg, rem_reg[STEP_W-1:0]);
                    state_next            = pss_pkg::ST_STEP_MUL;
                end
            end
            pss_pkg::ST_STEP_MUL:
            begin
                prod_next  = centered * $signed(spread_reg[cfg_sel]);
                gate_next  = {1'b0, draw_cur} < rd_data_reg;
                state_next = pss_pkg::ST_STEP_OUT;
            end
            pss_pkg::ST_STEP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    seq_id_next    = cfg_sel;
                    step_pos_next  = rem_reg[4:0];
                    gate_out_next  = gate_reg;
                    pitch_next     = prod_reg[25] ? 12'(-{1'b0, qsat}) : {1'b0, qsat};
                    last_next      = (seq_reg == last_seq_reg);
                    if (seq_reg == last_seq_reg)
                    begin
                        state_next = pss_pkg::ST_IDLE;
                    end
                    else
                    begin
                        seq_next   = seq_reg + 1'b1;
                        state_next = pss_pkg::ST_STEP_START;
                    end
                end
            end
            pss_pkg::ST_PAT:
            begin
                mem_we    = 1'b1;
                mem_wdata = pat_val;
                if (pat_reg >= pss_pkg::PATTERN_RANDOM)
                begin
                    lfsr_next = lfsr_step;
                end
                idx_next = idx_reg + 1'b1;
                if (int'(idx_reg) == STEP_COUNT - 1)
                begin
                    state_next = pss_pkg::ST_IDLE;
                end
            end
            pss_pkg::ST_RMW_READ:
            begin
                mem_re = 1'b1;
                if (cmd_reg == pss_pkg::CMD_DIMINISH)
                begin
                    mem_raddr = addr_of(seq_reg, dim_src[STEP_W-1:0]);
                end
                state_next = pss_pkg::ST_RMW_WRITE;
            end
            pss_pkg::ST_RMW_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = (cmd_reg == pss_pkg::CMD_DIMINISH) ? rd_data_reg
                            : 13'(pss_pkg::Q12_ONE) - rd_data_reg;
                idx_next  = idx_reg + 1'b1;
                state_next = (int'(idx_reg) == STEP_COUNT - 1) ? pss_pkg::ST_IDLE
                                                               : pss_pkg::ST_RMW_READ;
            end
            default:
            begin
                state_next = pss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pss_pkg::ST_CLEAR;
            clr_reg       <= '0;
            idx_reg       <= '0;
            seq_reg       <= '0;
            last_seq_reg  <= '0;
            one_reg       <= 1'b0;
            cmd_reg       <= pss_pkg::CMD_CLOCK_ALL;
            armed_reg     <= 1'b0;
            lfsr_reg      <= pss_pkg::LFSR_SEED;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < SEQ_COUNT; s++)
            begin
                pos_reg[s]     <= 6'h3F;
                started_reg[s] <= 1'b0;
                slen_reg[s]    <= 7'(STEP_COUNT);
            end
            for (int c = 0; c < 4; c++)
            begin
                length_reg[c] <= 6'd32;
                spread_reg[c] <= 12'd256;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            idx_reg       <= idx_next;
            seq_reg       <= seq_next;
            last_seq_reg  <= last_seq_next;
            one_reg       <= one_next;
            cmd_reg       <= cmd_next;
            armed_reg     <= armed_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            started_reg   <= started_next;
            slen_reg      <= slen_next;
            length_reg    <= length_next;
            spread_reg    <= spread_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg      <= pat_next;
        draw_reg     <= draw_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        gate_reg     <= gate_next;
        seq_id_reg   <= seq_id_next;
        step_pos_reg <= step_pos_next;
        gate_out_reg <= gate_out_next;
        pitch_reg    <= pitch_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign seq_id    = seq_id_reg;
    assign step_pos  = step_pos_reg;
    assign gate      = gate_out_reg;
    assign pitch     = pitch_reg;
    assign last      = last_reg;

    `PSS_ASSERT_IMPL(a_no_rw_same_entry, mem_we && mem_re, mem_waddr != mem_raddr,
        "store read and write hit the same entry")
    `PSS_ASSERT_IMPL(a_pitch_range, out_valid_reg,
        $signed(pitch_reg) <= 12'sd1024 && $signed(pitch_reg) >= -12'sd1024,
        "pitch outside the saturation range")
    `PSS_ASSERT_NEXT(a_mod_to_read, state_reg == pss_pkg::ST_STEP_MOD && rem_reg < len_reg,
        state_reg == pss_pkg::ST_STEP_MUL,
        "modulo step did not hand over to the store read")
    `PSS_ASSERT_IMPL(a_clear_blocks_input, state_reg == pss_pkg::ST_CLEAR,
        !in_ready && mem_we && !mem_re,
        "item path active during the clearing pass")

endmodule
